/* hw/rtl/bhr_pkg.sv */
package bhr_pkg;

  // Request kinds
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_FETCH  = 7'b0000010,
    ST_LOAD   = 7'b0000100,
    ST_LVL_RD = 7'b0001000,
    ST_PICK   = 7'b0010000,
    ST_SWAP   = 7'b0100000,
    ST_RESULT = 7'b1000000
  } bhr_state_e;

endpackage

/* hw/rtl/bhr_store.sv */
module bhr_store #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32,
  localparam int unsigned AddrW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [AddrW-1:0]     raddr_a_i,
  input  logic [AddrW-1:0]     raddr_b_i,
  output logic [WORD_BITS-1:0] rdata_a_o,
  output logic [WORD_BITS-1:0] rdata_b_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read on both ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* hw/rtl/binary_heap_root_remove.sv */
// Channel   Direction  Signals                                   Handshake
// request   in         kind_i, value_i                           start_i & !busy_o
// result    out        top_value_o, entry_count_o, status_o      done_o, one cycle
// config    in         cfg_heap_order_i                          cfg_valid_i & cfg_ready_o
//
// Append and rejected requests raise done_o in the cycle after the accepting edge.
// Remove walks the heap with one shared comparator: FETCH and LOAD fetch the last entry
// (LOAD goes straight to done_o when that empties the heap), then each level runs read,
// pick and swap until the walk ends at a leaf or a compare stops it. busy_o drops after
// the done_o cycle; no result stall.
// Reset empties the heap and selects min ordering; the store itself is not cleared.
module binary_heap_root_remove
  import bhr_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32,
  localparam int unsigned AddrW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW     = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               kind_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic signed [31:0] top_value_o,
  output logic [CntW-1:0]    entry_count_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_heap_order_i
);

  localparam int unsigned IdxW = AddrW + 2;

  bhr_state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] pick_q, pick_d;
  logic [1:0]       status_q, status_d;
  logic             order_q;

  logic signed [WORD_BITS-1:0] x_q, x_d;
  logic signed [WORD_BITS-1:0] child_q, child_d;
  logic signed [WORD_BITS-1:0] top_q;

  logic                 we;
  logic [AddrW-1:0]     waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [AddrW-1:0]     raddr_a, raddr_b;
  logic [WORD_BITS-1:0] rdata_a, rdata_b;

  logic signed [WORD_BITS-1:0] cmp_a, cmp_b;
  logic                        cmp_better;

  logic [IdxW-1:0]     left_idx, right_idx, count_ext;
  logic signed [63:0]  value_wide;
  logic signed [63:0]  top_wide;

  assign left_idx   = {1'b0, idx_q, 1'b1};
  assign right_idx  = left_idx + IdxW'(1);
  assign count_ext  = IdxW'(count_q);
  assign value_wide = 64'(value_i);
  assign top_wide   = 64'(top_q);

  // Shared ordering comparator: true when cmp_a belongs above cmp_b
  assign cmp_better = order_q ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

  bhr_store #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    pick_d   = pick_q;
    status_d = status_q;
    x_d      = x_q;
    child_d  = child_q;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = x_q;
    raddr_a  = AddrW'(count_q - CntW'(1));
    raddr_b  = right_idx[AddrW-1:0];
    cmp_a    = child_q;
    cmp_b    = x_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d  = ST_RESULT;
          status_d = STATUS_DONE;
          if (kind_i == KIND_APPEND) begin
            if (count_q >= CntW'(DEPTH)) begin
              status_d = STATUS_FULL;
            end else begin
              we      = 1'b1;
              waddr   = AddrW'(count_q);
              wdata   = value_wide[WORD_BITS-1:0];
              count_d = count_q + CntW'(1);
            end
          end else if (count_q == '0) begin
            status_d = STATUS_EMPTY;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        x_d     = rdata_a;
        count_d = count_q - CntW'(1);
        idx_d   = '0;
        state_d = (count_q == CntW'(1)) ? ST_RESULT : ST_LVL_RD;
      end
      ST_LVL_RD: begin
        if (left_idx >= count_ext) begin
          // leaf reached: drop the sifted entry here
          we      = 1'b1;
          state_d = ST_RESULT;
        end else begin
          raddr_a = left_idx[AddrW-1:0];
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        cmp_a = rdata_a;
        cmp_b = rdata_b;
        if (right_idx >= count_ext || cmp_better) begin
          pick_d  = left_idx[AddrW-1:0];
          child_d = rdata_a;
        end else begin
          pick_d  = right_idx[AddrW-1:0];
          child_d = rdata_b;
        end
        state_d = ST_SWAP;
      end
      ST_SWAP: begin
        we = 1'b1;
        if (cmp_better) begin
          // move the child up and descend
          wdata   = child_q;
          idx_d   = pick_q;
          state_d = ST_LVL_RD;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      status_q <= STATUS_DONE;
      order_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
      if (cfg_valid_i && cfg_ready_o) begin
        order_q <= cfg_heap_order_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pick_q  <= pick_d;
    x_q     <= x_d;
    child_q <= child_d;
    // shadow the root so the result needs no extra read
    if (we && waddr == '0) begin
      top_q <= wdata;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign done_o        = (state_q == ST_RESULT);
  assign entry_count_o = count_q;
  assign status_o      = status_q;
  assign top_value_o   = (count_q == '0) ? 32'sd0 : top_wide[31:0];

endmodule
